FILE: rtl/core/imu_gd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imu_gd_pkg
// shared types, constants and the cordic angle table of the gesture detector
// ----------------------------------------------------------------------------
package imu_gd_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int CordicSteps  = (CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS;
  localparam int StepW        = $clog2(CordicSteps);
  localparam int CordicW      = 28;
  localparam int AngleW       = CordicW - 8;
  localparam int AtanW        = 23;
  localparam int AtanIdxW     = 5;

  localparam logic signed [CordicW-1:0] HalfTurn = CordicW'(180 * 65536);
  localparam logic signed [CordicW-1:0] RoundBias = CordicW'(128);

  typedef enum logic [3:0] {
    G_NONE        = 4'd0,
    G_JERK_FWD    = 4'd1,
    G_JERK_BACK   = 4'd2,
    G_TWIST_RIGHT = 4'd3,
    G_TWIST_LEFT  = 4'd4,
    G_TILT_LEFT   = 4'd5,
    G_TILT_RIGHT  = 4'd6,
    G_UP          = 4'd7,
    G_DOWN        = 4'd8
  } gesture_e;

  typedef enum logic [1:0] {
    CFG_JERK     = 2'd0,
    CFG_TWIST    = 2'd1,
    CFG_TILT     = 2'd2,
    CFG_COOLDOWN = 2'd3
  } cfg_idx_e;

  typedef enum logic {
    SEL_ROLL  = 1'b0,
    SEL_PITCH = 1'b1
  } cordic_sel_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_ROLL,
    S_ROLL_CHK,
    S_PITCH,
    S_PITCH_CHK,
    S_RESULT
  } ctrl_state_e;

  typedef struct packed {
    logic        load;
    logic        cordic_start;
    cordic_sel_e cordic_sel;
    logic        cordic_step;
    logic        res_we;
    gesture_e    res_gesture;
    logic        res_suppressed;
  } dp_cmd_t;

  typedef struct packed {
    logic suppressed;
    logic jerk_fwd;
    logic jerk_back;
    logic twist_right;
    logic twist_left;
    logic cordic_last;
    logic ang_pos;
    logic ang_neg;
    logic out_free;
  } dp_status_t;

  // atan(2^-i) in 1/65536 degree
  function automatic logic [AtanW-1:0] atan_entry(logic [AtanIdxW-1:0] idx);
    logic [AtanW-1:0] a;
    unique case (idx)
      5'd0:  a = 23'd2949120;
      5'd1:  a = 23'd1740967;
      5'd2:  a = 23'd919879;
      5'd3:  a = 23'd466945;
      5'd4:  a = 23'd234379;
      5'd5:  a = 23'd117305;
      5'd6:  a = 23'd58666;
      5'd7:  a = 23'd29335;
      5'd8:  a = 23'd14668;
      5'd9:  a = 23'd7334;
      5'd10: a = 23'd3667;
      5'd11: a = 23'd1833;
      5'd12: a = 23'd917;
      5'd13: a = 23'd458;
      5'd14: a = 23'd229;
      5'd15: a = 23'd115;
      5'd16: a = 23'd57;
      5'd17: a = 23'd29;
      5'd18: a = 23'd14;
      5'd19: a = 23'd7;
      5'd20: a = 23'd4;
      5'd21: a = 23'd2;
      5'd22: a = 23'd1;
      default: a = 23'd0;
    endcase
    return a;
  endfunction

endpackage

FILE: rtl/core/imu_gd_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imu_gd_ctrl
// sequencer: checks in priority order, runs the cordic up to twice, writes result
// ----------------------------------------------------------------------------
module imu_gd_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_tvalid_i,
  output logic                   s_tready_o,
  input  imu_gd_pkg::dp_status_t status_i,
  output imu_gd_pkg::dp_cmd_t    cmd_o
);

  imu_gd_pkg::ctrl_state_e state_q, state_d;
  imu_gd_pkg::gesture_e    code_q, code_d;
  logic                    supp_q, supp_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= imu_gd_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    code_q <= code_d;
    supp_q <= supp_d;
  end

  always_comb begin
    state_d    = state_q;
    code_d     = code_q;
    supp_d     = supp_q;
    s_tready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.cordic_sel  = imu_gd_pkg::SEL_ROLL;
    cmd_o.res_gesture = code_q;
    cmd_o.res_suppressed = supp_q;
    unique case (state_q)
      imu_gd_pkg::S_IDLE: begin
        s_tready_o = 1'b1;
        if (s_tvalid_i) begin
          cmd_o.load = 1'b1;
          state_d    = imu_gd_pkg::S_CHECK;
        end
      end
      imu_gd_pkg::S_CHECK: begin
        supp_d  = 1'b0;
        state_d = imu_gd_pkg::S_RESULT;
        priority if (status_i.suppressed) begin
          supp_d = 1'b1;
          code_d = imu_gd_pkg::G_NONE;
        end else if (status_i.jerk_fwd) begin
          code_d = imu_gd_pkg::G_JERK_FWD;
        end else if (status_i.jerk_back) begin
          code_d = imu_gd_pkg::G_JERK_BACK;
        end else if (status_i.twist_right) begin
          code_d = imu_gd_pkg::G_TWIST_RIGHT;
        end else if (status_i.twist_left) begin
          code_d = imu_gd_pkg::G_TWIST_LEFT;
        end else begin
          cmd_o.cordic_start = 1'b1;
          cmd_o.cordic_sel   = imu_gd_pkg::SEL_ROLL;
          state_d            = imu_gd_pkg::S_ROLL;
        end
      end
      imu_gd_pkg::S_ROLL: begin
        cmd_o.cordic_step = 1'b1;
        if (status_i.cordic_last) begin
          state_d = imu_gd_pkg::S_ROLL_CHK;
        end
      end
      imu_gd_pkg::S_ROLL_CHK: begin
        state_d = imu_gd_pkg::S_RESULT;
        priority if (status_i.ang_pos) begin
          code_d = imu_gd_pkg::G_TILT_LEFT;
        end else if (status_i.ang_neg) begin
          code_d = imu_gd_pkg::G_TILT_RIGHT;
        end else begin
          cmd_o.cordic_start = 1'b1;
          cmd_o.cordic_sel   = imu_gd_pkg::SEL_PITCH;
          state_d            = imu_gd_pkg::S_PITCH;
        end
      end
      imu_gd_pkg::S_PITCH: begin
        cmd_o.cordic_step = 1'b1;
        if (status_i.cordic_last) begin
          state_d = imu_gd_pkg::S_PITCH_CHK;
        end
      end
      imu_gd_pkg::S_PITCH_CHK: begin
        state_d = imu_gd_pkg::S_RESULT;
        priority if (status_i.ang_pos) begin
          code_d = imu_gd_pkg::G_UP;
        end else if (status_i.ang_neg) begin
          code_d = imu_gd_pkg::G_DOWN;
        end else begin
          code_d = imu_gd_pkg::G_NONE;
        end
      end
      imu_gd_pkg::S_RESULT: begin
        if (status_i.out_free) begin
          cmd_o.res_we = 1'b1;
          state_d      = imu_gd_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = imu_gd_pkg::S_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/core/imu_gd_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imu_gd_datapath
// sample and state registers, threshold checks, serial cordic, output register
// ----------------------------------------------------------------------------
module imu_gd_datapath (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [95:0]            s_tdata_i,
  input  logic                   cfg_we_i,
  input  logic [1:0]             cfg_idx_i,
  input  logic [15:0]            cfg_data_i,
  input  imu_gd_pkg::dp_cmd_t    cmd_i,
  output imu_gd_pkg::dp_status_t status_o,
  input  logic                   m_tready_i,
  output logic                   m_tvalid_o,
  output logic [7:0]             m_tdata_o,
  output logic                   m_tuser_o
);

  localparam int W = imu_gd_pkg::CordicW;

  logic [14:0] jerk_thr_q, twist_thr_q;
  logic [15:0] tilt_thr_q, cooldown_q;
  logic signed [15:0] ax_q, ay_q, az_q, rz_q;
  logic [31:0] now_q;
  logic signed [15:0] prev_ax_q;
  logic [31:0] last_time_q;
  logic signed [W-1:0] x_q, y_q, z_q;
  logic [imu_gd_pkg::StepW-1:0] step_q;
  logic out_valid_q;
  imu_gd_pkg::gesture_e out_gesture_q;
  logic out_supp_q;

  logic [31:0] elapsed;
  logic signed [16:0] dax, jt, tt, rz_ext;
  logic signed [15:0] yi, xi;
  logic signed [W-1:0] x0, y0, x_sh, y_sh, atan_v;
  logic signed [imu_gd_pkg::AngleW-1:0] ang;
  logic signed [W-1:0] z_round;
  logic signed [imu_gd_pkg::AngleW:0] ang_ext, lt_ext;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      jerk_thr_q  <= 15'd640;
      twist_thr_q <= 15'd1280;
      tilt_thr_q  <= 16'd6400;
      cooldown_q  <= 16'd400;
    end else if (cfg_we_i) begin
      unique case (imu_gd_pkg::cfg_idx_e'(cfg_idx_i))
        imu_gd_pkg::CFG_JERK:     jerk_thr_q  <= cfg_data_i[14:0];
        imu_gd_pkg::CFG_TWIST:    twist_thr_q <= cfg_data_i[14:0];
        imu_gd_pkg::CFG_TILT:     tilt_thr_q  <= cfg_data_i;
        imu_gd_pkg::CFG_COOLDOWN: cooldown_q  <= cfg_data_i;
      endcase
    end
  end

  // sample capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      ax_q  <= s_tdata_i[15:0];
      ay_q  <= s_tdata_i[31:16];
      az_q  <= s_tdata_i[47:32];
      rz_q  <= s_tdata_i[63:48];
      now_q <= s_tdata_i[95:64];
    end
  end

  // quick checks
  always_comb begin
    elapsed = now_q - last_time_q;
    dax     = {ax_q[15], ax_q} - {prev_ax_q[15], prev_ax_q};
    jt      = $signed({2'b00, jerk_thr_q});
    tt      = $signed({2'b00, twist_thr_q});
    rz_ext  = {rz_q[15], rz_q};
  end

  // cordic operands and pre-rotation
  always_comb begin
    yi = (cmd_i.cordic_sel == imu_gd_pkg::SEL_PITCH) ? ax_q : ay_q;
    xi = az_q;
    x0 = $signed({{(W-24){xi[15]}}, xi, 8'b0});
    y0 = $signed({{(W-24){yi[15]}}, yi, 8'b0});
    x_sh   = x_q >>> step_q;
    y_sh   = y_q >>> step_q;
    atan_v = $signed({{(W-imu_gd_pkg::AtanW){1'b0}},
                      imu_gd_pkg::atan_entry(imu_gd_pkg::AtanIdxW'(step_q))});
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cordic_start) begin
      step_q <= '0;
      if (xi[15]) begin
        x_q <= -x0;
        y_q <= -y0;
        z_q <= yi[15] ? -imu_gd_pkg::HalfTurn : imu_gd_pkg::HalfTurn;
      end else begin
        x_q <= x0;
        y_q <= y0;
        z_q <= '0;
      end
    end else if (cmd_i.cordic_step) begin
      step_q <= step_q + 1'b1;
      if (!y_q[W-1] && (y_q != '0)) begin
        x_q <= x_q + y_sh;
        y_q <= y_q - x_sh;
        z_q <= z_q + atan_v;
      end else if (y_q[W-1]) begin
        x_q <= x_q - y_sh;
        y_q <= y_q + x_sh;
        z_q <= z_q - atan_v;
      end
    end
  end

  always_comb begin
    z_round = z_q + imu_gd_pkg::RoundBias;
    ang     = z_round[W-1:8];
    ang_ext = {ang[imu_gd_pkg::AngleW-1], ang};
    lt_ext  = $signed({{(imu_gd_pkg::AngleW-15){1'b0}}, tilt_thr_q});
  end

  // gesture state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_ax_q   <= '0;
      last_time_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.res_we) begin
        out_valid_q <= 1'b1;
        if (!cmd_i.res_suppressed) begin
          prev_ax_q <= ax_q;
          if (cmd_i.res_gesture != imu_gd_pkg::G_NONE) begin
            last_time_q <= now_q;
          end
        end
      end else if (m_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_we) begin
      out_gesture_q <= cmd_i.res_gesture;
      out_supp_q    <= cmd_i.res_suppressed;
    end
  end

  always_comb begin
    status_o.suppressed  = elapsed < {16'b0, cooldown_q};
    status_o.jerk_fwd    = dax > jt;
    status_o.jerk_back   = dax < -jt;
    status_o.twist_right = rz_ext > tt;
    status_o.twist_left  = rz_ext < -tt;
    status_o.cordic_last = step_q == imu_gd_pkg::StepW'(imu_gd_pkg::CordicSteps - 1);
    status_o.ang_pos     = ang_ext > lt_ext;
    status_o.ang_neg     = ang_ext < -lt_ext;
    status_o.out_free    = !out_valid_q || m_tready_i;
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = {4'b0, out_gesture_q};
  assign m_tuser_o  = out_supp_q;

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.res_we |-> (!out_valid_q || m_tready_i))
    else $error("result written over a beat still waiting");

  a_supp_keeps_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.res_we && cmd_i.res_suppressed |=> $stable(prev_ax_q) && $stable(last_time_q))
    else $error("suppressed sample changed gesture state");

  a_gesture_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.res_we && !cmd_i.res_suppressed && (cmd_i.res_gesture != imu_gd_pkg::G_NONE)
    |=> last_time_q == $past(now_q))
    else $error("gesture time not recorded");

endmodule

FILE: rtl/core/imu_gesture_detector_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imu_gesture_detector_core
// classifies one gesture per imu sample: jerk, twist, roll tilt, pitch tilt
// ----------------------------------------------------------------------------
//  channel   dir  fields (lowest bit up)
//  s_*       in   tdata: accel_x[15:0] accel_y[31:16] accel_z[47:32]
//                        rate_z[63:48] now_ms[95:64]
//  m_*       out  tdata: gesture[3:0], zero pad; tuser: suppressed
//  cfg_*     in   idx 0 jerk, 1 twist, 2 tilt, 3 cooldown; data 16 bit
//
//  suppressed, jerk and twist samples pass from accept through the check state
//  to the result state; a roll tilt adds one cordic run and a pitch verdict a
//  second, the two 16-step serial cordic runs sharing one shift-add unit
//  a new beat is taken once the result sits in the output register
//  a stalled output holds the sequencer in its result state
//  reset restores the default thresholds and clears the gesture state
// ----------------------------------------------------------------------------
module imu_gesture_detector_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  output logic        s_tready_o,
  input  logic [95:0] s_tdata_i,   // accel_x, accel_y, accel_z, rate_z, now_ms
  output logic        m_tvalid_o,
  input  logic        m_tready_i,
  output logic [7:0]  m_tdata_o,   // gesture, zero pad
  output logic        m_tuser_o,   // suppressed
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i
);

  imu_gd_pkg::dp_cmd_t    cmd;
  imu_gd_pkg::dp_status_t status;

  imu_gd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  imu_gd_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tdata_i  (s_tdata_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .m_tready_i (m_tready_i),
    .m_tvalid_o (m_tvalid_o),
    .m_tdata_o  (m_tdata_o),
    .m_tuser_o  (m_tuser_o)
  );

endmodule
